>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// assertion that is switched off while reset is high
`define FCV_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fcv assertion failed");
// assertion that is also checked while reset is high
`define FCV_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fcv assertion failed");
`else
`define FCV_ASSERT(lbl, clk, rst, prop)
`define FCV_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

>>> hdl/fcv_pkg.sv
// ---------------------------------------------------------------------------
// fcv_pkg
// shared types, constants and helpers of the face cull block
// ---------------------------------------------------------------------------
package fcv_pkg;

  // reject reason codes
  localparam logic [2:0] REASON_KEEP     = 3'd0;
  localparam logic [2:0] REASON_BACKFACE = 3'd1;
  localparam logic [2:0] REASON_NEAR     = 3'd2;
  localparam logic [2:0] REASON_HORIZ    = 3'd3;
  localparam logic [2:0] REASON_VERT     = 3'd4;

  // register indexes on the apb port
  localparam logic [2:0] REG_CAMERA_X = 3'd0;
  localparam logic [2:0] REG_CAMERA_Y = 3'd1;
  localparam logic [2:0] REG_CAMERA_Z = 3'd2;
  localparam logic [2:0] REG_SINE     = 3'd3;
  localparam logic [2:0] REG_COSINE   = 3'd4;
  localparam logic [2:0] REG_FOCAL    = 3'd5;

  // reset values
  localparam logic signed [15:0] COSINE_RESET = 16'sd16384;
  localparam logic [11:0]        FOCAL_RESET  = 12'd120;

  // geometry constants
  localparam int Q14_BITS   = 14;
  localparam int ROUND_HALF = 128;
  localparam logic signed [20:0] NEAR_LIMIT  = 21'sd8;
  localparam logic signed [7:0]  HORIZ_SLOPE = 8'sd60;
  localparam logic signed [7:0]  VERT_SLOPE  = 8'sd40;

  // camera and view setup seen by the datapath
  typedef struct packed {
    logic signed [13:0] cam_x;
    logic signed [13:0] cam_y;
    logic signed [13:0] cam_z;
    logic signed [15:0] sine;
    logic signed [15:0] cosine;
    logic [11:0]        focal;
  } fcv_cfg_t;

  // q8 camera coordinate to nearest whole unit
  function automatic logic signed [13:0] round_camera(input logic signed [20:0] q8);
    logic [21:0] sum;
    sum = {q8[20], q8} + 22'(ROUND_HALF);
    return sum[21:8];
  endfunction

endpackage

>>> hdl/fcv_if.sv
// ---------------------------------------------------------------------------
// fcv channels
// valid/ready channels for face records and cull results
// ---------------------------------------------------------------------------
interface fcv_face_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [15:0] plane_offset;
  logic signed [15:0] centre_x;
  logic signed [15:0] centre_y;
  logic signed [15:0] centre_z;
  logic [14:0]        sphere_radius;
  logic [15:0]        face_tag;

  modport source (
    output valid, normal_x, normal_y, normal_z, plane_offset,
    output centre_x, centre_y, centre_z, sphere_radius, face_tag,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, plane_offset,
    input  centre_x, centre_y, centre_z, sphere_radius, face_tag,
    output ready
  );
endinterface

interface fcv_result_if;
  logic        valid;
  logic        ready;
  logic        face_visible;
  logic [2:0]  reject_reason;
  logic [15:0] face_tag_out;

  modport source (
    output valid, face_visible, reject_reason, face_tag_out,
    input  ready
  );
  modport sink (
    input  valid, face_visible, reject_reason, face_tag_out,
    output ready
  );
endinterface

>>> hdl/fcv_cfg.sv
// ---------------------------------------------------------------------------
// fcv_cfg
// apb register file for camera position, view yaw and focal length
// ---------------------------------------------------------------------------
module fcv_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output fcv_pkg::fcv_cfg_t  cfg
);

  logic [20:0]       camera_x_q8;
  logic [20:0]       camera_y_q8;
  logic [20:0]       camera_z_q8;
  logic [15:0]       view_sine;
  logic [15:0]       view_cosine;
  logic [11:0]       focal_scale;
  logic [2:0]        reg_index;
  logic              wr_en;
  logic signed [13:0] wr_rounded;

  assign pready     = 1'b1;
  assign reg_index  = paddr[4:2];
  assign wr_en      = psel && penable && pwrite;
  assign wr_rounded = fcv_pkg::round_camera(pwdata[20:0]);

  // register writes, rounded camera kept alongside the raw value
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x_q8  <= '0;
      camera_y_q8  <= '0;
      camera_z_q8  <= '0;
      view_sine    <= '0;
      view_cosine  <= fcv_pkg::COSINE_RESET;
      focal_scale  <= fcv_pkg::FOCAL_RESET;
      cfg          <= '{cam_x: '0, cam_y: '0, cam_z: '0, sine: '0,
                        cosine: fcv_pkg::COSINE_RESET, focal: fcv_pkg::FOCAL_RESET};
    end else if (wr_en) begin
      case (reg_index)
        fcv_pkg::REG_CAMERA_X: begin
          camera_x_q8 <= pwdata[20:0];
          cfg.cam_x   <= wr_rounded;
        end
        fcv_pkg::REG_CAMERA_Y: begin
          camera_y_q8 <= pwdata[20:0];
          cfg.cam_y   <= wr_rounded;
        end
        fcv_pkg::REG_CAMERA_Z: begin
          camera_z_q8 <= pwdata[20:0];
          cfg.cam_z   <= wr_rounded;
        end
        fcv_pkg::REG_SINE: begin
          view_sine  <= pwdata[15:0];
          cfg.sine   <= pwdata[15:0];
        end
        fcv_pkg::REG_COSINE: begin
          view_cosine <= pwdata[15:0];
          cfg.cosine  <= pwdata[15:0];
        end
        fcv_pkg::REG_FOCAL: begin
          focal_scale <= pwdata[11:0];
          cfg.focal   <= pwdata[11:0];
        end
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_index)
      fcv_pkg::REG_CAMERA_X: prdata = {11'b0, camera_x_q8};
      fcv_pkg::REG_CAMERA_Y: prdata = {11'b0, camera_y_q8};
      fcv_pkg::REG_CAMERA_Z: prdata = {11'b0, camera_z_q8};
      fcv_pkg::REG_SINE:     prdata = {16'b0, view_sine};
      fcv_pkg::REG_COSINE:   prdata = {16'b0, view_cosine};
      fcv_pkg::REG_FOCAL:    prdata = {20'b0, focal_scale};
      default:               prdata = '0;
    endcase
  end

endmodule

>>> hdl/fcv_pipe.sv
// ---------------------------------------------------------------------------
// fcv_pipe
// five stage cull datapath: plane side, yaw rotation, slope tests
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fcv_pipe (
  input  logic               clk,
  input  logic               rst,
  input  fcv_pkg::fcv_cfg_t  cfg,
  fcv_face_if.sink           face,
  fcv_result_if.source       result
);

  logic signed [13:0] cam_x, cam_y, cam_z;
  logic signed [15:0] sine, cosine;
  logic [11:0]        focal;

  assign cam_x  = cfg.cam_x;
  assign cam_y  = cfg.cam_y;
  assign cam_z  = cfg.cam_z;
  assign sine   = cfg.sine;
  assign cosine = cfg.cosine;
  assign focal  = cfg.focal;

  // per stage valid and advance
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || result.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign face.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= face.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // stage 1: normal products and camera-relative centre
  logic signed [29:0] prod_x1, prod_y1, prod_z1;
  logic signed [15:0] dist1;
  logic signed [16:0] dx1, dy1, dz1;
  logic [14:0]        radius1;
  logic [15:0]        tag1;

  always_ff @(posedge clk) begin
    if (en1) begin
      prod_x1 <= face.normal_x * cam_x;
      prod_y1 <= face.normal_y * cam_y;
      prod_z1 <= face.normal_z * cam_z;
      dist1   <= face.plane_offset;
      dx1     <= {face.centre_x[15], face.centre_x} - {{3{cam_x[13]}}, cam_x};
      dy1     <= {face.centre_y[15], face.centre_y} - {{3{cam_y[13]}}, cam_y};
      dz1     <= {face.centre_z[15], face.centre_z} - {{3{cam_z[13]}}, cam_z};
      radius1 <= face.sphere_radius;
      tag1    <= face.face_tag;
    end
  end

  // stage 2: plane side sign and yaw products
  logic [31:0]        side_sum;
  logic               back2;
  logic signed [32:0] cdx2, sdy2, cdy2, sdx2;
  logic signed [16:0] dz2;
  logic [14:0]        radius2;
  logic [15:0]        tag2;

  assign side_sum = {{2{prod_x1[29]}}, prod_x1} + {{2{prod_y1[29]}}, prod_y1}
                  + {{2{prod_z1[29]}}, prod_z1} - {{2{dist1[15]}}, dist1, 14'b0};

  always_ff @(posedge clk) begin
    if (en2) begin
      back2   <= !side_sum[31];
      cdx2    <= cosine * dx1;
      sdy2    <= sine * dy1;
      cdy2    <= cosine * dy1;
      sdx2    <= sine * dx1;
      dz2     <= dz1;
      radius2 <= radius1;
      tag2    <= tag1;
    end
  end

  // stage 3: floored depth, lateral and vertical distances
  logic [33:0]        depth_sum, lat_sum;
  logic signed [19:0] lat;
  logic signed [19:0] depth3;
  logic [19:0]        horiz3;
  logic [16:0]        vert3;
  logic               back3;
  logic [14:0]        radius3;
  logic [15:0]        tag3;

  assign depth_sum = {cdx2[32], cdx2} + {sdy2[32], sdy2};
  assign lat_sum   = {cdy2[32], cdy2} - {sdx2[32], sdx2};
  assign lat       = lat_sum[33:fcv_pkg::Q14_BITS];

  always_ff @(posedge clk) begin
    if (en3) begin
      depth3  <= depth_sum[33:fcv_pkg::Q14_BITS];
      horiz3  <= lat[19] ? 20'(-lat) : 20'(lat);
      vert3   <= dz2[16] ? 17'(-dz2) : 17'(dz2);
      back3   <= back2;
      radius3 <= radius2;
      tag3    <= tag2;
    end
  end

  // stage 4: near test and slope products
  logic signed [20:0] near_sum;
  logic [19:0]        hdiff;
  logic [16:0]        vdiff;
  logic               back4, near4, hgt4, vgt4;
  logic [31:0]        hprod4;
  logic [28:0]        vprod4;
  logic signed [26:0] hlim4, vlim4;
  logic [15:0]        tag4;

  assign near_sum = {depth3[19], depth3} + {6'b0, radius3};
  assign hdiff    = horiz3 - {5'b0, radius3};
  assign vdiff    = vert3 - {2'b0, radius3};

  always_ff @(posedge clk) begin
    if (en4) begin
      back4  <= back3;
      near4  <= near_sum < fcv_pkg::NEAR_LIMIT;
      hgt4   <= horiz3 > {5'b0, radius3};
      vgt4   <= vert3 > {2'b0, radius3};
      hprod4 <= hdiff * focal;
      vprod4 <= vdiff * focal;
      hlim4  <= depth3 * fcv_pkg::HORIZ_SLOPE;
      vlim4  <= depth3 * fcv_pkg::VERT_SLOPE;
      tag4   <= tag3;
    end
  end

  // stage 5: compares and reason priority into the output register
  logic       hfail, vfail;
  logic [2:0] reason_next;
  logic [2:0] reason5;
  logic       visible5;
  logic [15:0] tag5;
  logic       result_keep;

  assign hfail = hgt4 && ($signed({1'b0, hprod4}) > $signed({{6{hlim4[26]}}, hlim4}));
  assign vfail = vgt4 && ($signed({4'b0, vprod4}) > $signed({{6{vlim4[26]}}, vlim4}));

  always_comb begin
    if (back4)      reason_next = fcv_pkg::REASON_BACKFACE;
    else if (near4) reason_next = fcv_pkg::REASON_NEAR;
    else if (hfail) reason_next = fcv_pkg::REASON_HORIZ;
    else if (vfail) reason_next = fcv_pkg::REASON_VERT;
    else            reason_next = fcv_pkg::REASON_KEEP;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      reason5  <= reason_next;
      visible5 <= reason_next == fcv_pkg::REASON_KEEP;
      tag5     <= tag4;
    end
  end

  assign result.valid         = v5;
  assign result.reject_reason = reason5;
  assign result.face_visible  = visible5;
  assign result.face_tag_out  = tag5;

  assign result_keep = (result.reject_reason == fcv_pkg::REASON_KEEP);

  // checks
  `FCV_ASSERT(a_accept_fills_s1, clk, rst, face.valid && face.ready |=> v1)
  `FCV_ASSERT(a_stalled_s3_holds, clk, rst, v3 && !en4 |=> v3 && $stable(tag3))
  `FCV_ASSERT(a_visible_matches, clk, rst, result.valid |-> result.face_visible == result_keep)
  `FCV_ASSERT_NORST(a_reset_empties, clk, rst |=> !result.valid)

endmodule

>>> hdl/face_backface_and_view_cull_top.sv
// ---------------------------------------------------------------------------
// face_backface_and_view_cull_top
// backface and bounding sphere view cull of face records
// ---------------------------------------------------------------------------
// usage:
//   face channel (valid/ready) carries one face record per transaction:
//   q14 normal, plane offset, sphere centre and radius, and a tag.
//   result channel returns one transaction per face: visible flag,
//   reject reason and the tag, in input order.
//   the apb port sets camera position (q8), view sine/cosine (q14) and
//   focal length; write it only while no face is in flight.
//   each accepted face passes through five register stages before its
//   result is presented.
//   throughput: one face per cycle unless a stall reaches face ready; the
//   stage-two yaw and stage-four slope multipliers take a face as it advances.
//   reset clears all stage valid bits and loads the register defaults
//   (camera at origin, yaw zero, focal 120).
//   when the receiver stalls, the output stage holds its transaction and
//   earlier stages keep filling bubbles before face ready drops.
// ---------------------------------------------------------------------------
module face_backface_and_view_cull_top (
  input  logic          clk,
  input  logic          rst,
  fcv_face_if.sink      face,
  fcv_result_if.source  result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  fcv_pkg::fcv_cfg_t cfg;

  // register file
  fcv_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // cull datapath
  fcv_pipe u_pipe (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .face   (face),
    .result (result)
  );

endmodule
